// ----- rtl/generational_handle_table_defines.svh -----
// ----------------------------------------------------------------------------
// Generational handle table: assertion macros
// Shared property shorthands; every user has ports named clock and reset.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_TABLE_DEFINES_SVH
`define GENERATIONAL_HANDLE_TABLE_DEFINES_SVH

// Same-cycle implication, off while reset is high.
`define GHT_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high.
`define GHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/ght_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle table: shared package
// Command and status codes, item structs and generation helpers.
// ----------------------------------------------------------------------------
package ght_pkg;

   localparam int KIND_W    = 8;
   localparam int GEN_W     = 24;
   localparam int PAYLOAD_W = 64;
   localparam int HANDLE_W  = 64;
   localparam int LIVE_W    = 11;
   localparam int SLOT_W    = 32;

   typedef enum logic [1:0] {
      CMD_ACQUIRE = 2'd0,
      CMD_RESOLVE = 2'd1,
      CMD_REBIND  = 2'd2,
      CMD_RELEASE = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_FULL    = 2'd2
   } status_type;

   typedef enum logic {
      STATE_IDLE = 1'b0,
      STATE_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      cmd_type                command;
      logic [HANDLE_W-1:0]    handle;
      logic [KIND_W-1:0]      match_kind;
      logic [KIND_W-1:0]      new_kind;
      logic [PAYLOAD_W-1:0]   payload;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [HANDLE_W-1:0]    handle_out;
      logic [PAYLOAD_W-1:0]   payload_out;
      logic [LIVE_W-1:0]      live_entries;
   } rsp_type;

   // Zero is never a live generation.
   function automatic logic [GEN_W-1:0] gen_nonzero(input logic [GEN_W-1:0] g);
      return (g == '0) ? GEN_W'(1) : g;
   endfunction

   // Advance with 24-bit wrap, skipping zero.
   function automatic logic [GEN_W-1:0] gen_advance(input logic [GEN_W-1:0] g);
      logic [GEN_W-1:0] n;
      n = g + GEN_W'(1);
      return gen_nonzero(n);
   endfunction

endpackage

// ----- rtl/ght_slot_ram.sv -----
// ----------------------------------------------------------------------------
// Generational handle table: slot memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ght_slot_ram #(
   parameter int WIDTH = 108,
   parameter int DEPTH = 1024,
   parameter int AW    = 10
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ght_exec.sv -----
// ----------------------------------------------------------------------------
// Generational handle table: command execution
// Check the handle against the slot read, build the write-back and the
// result, and hold free-list head, fill count and occupancy count.
// ----------------------------------------------------------------------------
`include "generational_handle_table_defines.svh"

module ght_exec #(
   parameter int SLOT_COUNT = 1024,
   parameter int IW         = 10,
   parameter int PW         = 11,
   parameter int EW         = 108
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  ght_pkg::req_type req,
   input  logic [EW-1:0]    rd_data,
   output logic [PW-1:0]    head,
   output logic             wr_en,
   output logic [IW-1:0]    wr_addr,
   output logic [EW-1:0]    wr_data,
   output ght_pkg::rsp_type rsp
);

   localparam int OCC_LSB  = 0;
   localparam int NEXT_LSB = OCC_LSB + 1;
   localparam int GEN_LSB  = NEXT_LSB + PW;
   localparam int KIND_LSB = GEN_LSB + ght_pkg::GEN_W;
   localparam int PL_LSB   = KIND_LSB + ght_pkg::KIND_W;
   localparam int CW       = (PW > ght_pkg::LIVE_W) ? PW : ght_pkg::LIVE_W;
   localparam logic [PW-1:0] SLOT_PTR = PW'(SLOT_COUNT);
   localparam logic [ght_pkg::SLOT_W-1:0] SLOT_LIMIT = ght_pkg::SLOT_W'(SLOT_COUNT);

   logic [PW-1:0] head_ff, head_in;
   logic [PW-1:0] fill_ff, fill_in;
   logic [PW-1:0] count_ff, count_in;

   logic [ght_pkg::SLOT_W-1:0]    enc;
   logic [ght_pkg::SLOT_W-1:0]    enc_m1;
   logic [ght_pkg::GEN_W-1:0]     h_gen;
   logic [ght_pkg::KIND_W-1:0]    h_kind;
   logic [PW-1:0]                 slot_pos;
   logic                          fresh;
   logic                          valid;
   logic                          e_occ;
   logic [PW-1:0]                 e_next;
   logic [ght_pkg::GEN_W-1:0]     e_gen;
   logic [ght_pkg::KIND_W-1:0]    e_kind;
   logic [ght_pkg::PAYLOAD_W-1:0] e_payload;
   logic                          w_occ;
   logic [PW-1:0]                 w_next;
   logic [ght_pkg::GEN_W-1:0]     w_gen;
   logic [ght_pkg::KIND_W-1:0]    w_kind;
   logic [ght_pkg::PAYLOAD_W-1:0] w_payload;
   logic [CW-1:0]                 count_wide;

   assign enc    = req.handle[ght_pkg::SLOT_W-1:0];
   assign enc_m1 = enc - ght_pkg::SLOT_W'(1);
   assign h_gen  = req.handle[ght_pkg::SLOT_W +: ght_pkg::GEN_W];
   assign h_kind = req.handle[ght_pkg::HANDLE_W-1 -: ght_pkg::KIND_W];

   assign slot_pos = (req.command == ght_pkg::CMD_ACQUIRE) ? head_ff : enc_m1[PW-1:0];
   // Slots at or above the fill count were never written: read reset values.
   assign fresh    = (slot_pos >= fill_ff);

   always_comb begin
      if (fresh) begin
         e_occ     = 1'b0;
         e_next    = slot_pos + PW'(1);
         e_gen     = ght_pkg::GEN_W'(1);
         e_kind    = '0;
         e_payload = '0;
      end else begin
         e_occ     = rd_data[OCC_LSB];
         e_next    = rd_data[NEXT_LSB +: PW];
         e_gen     = rd_data[GEN_LSB +: ght_pkg::GEN_W];
         e_kind    = rd_data[KIND_LSB +: ght_pkg::KIND_W];
         e_payload = rd_data[PL_LSB +: ght_pkg::PAYLOAD_W];
      end
   end

   assign valid = (enc != '0) && (enc <= SLOT_LIMIT) && (h_gen != '0) && e_occ
                  && ((req.match_kind == '0) || (e_kind == req.match_kind))
                  && (e_gen == h_gen);

   always_comb begin
      rsp.status      = ght_pkg::STATUS_OK;
      rsp.handle_out  = '0;
      rsp.payload_out = '0;
      wr_en     = 1'b0;
      w_occ     = e_occ;
      w_next    = e_next;
      w_gen     = e_gen;
      w_kind    = e_kind;
      w_payload = e_payload;
      head_in   = head_ff;
      fill_in   = fill_ff;
      count_in  = count_ff;
      unique case (req.command)
         ght_pkg::CMD_ACQUIRE: begin
            if (head_ff >= SLOT_PTR) begin
               rsp.status = ght_pkg::STATUS_FULL;
            end else begin
               w_occ     = 1'b1;
               w_kind    = req.new_kind;
               w_payload = req.payload;
               w_gen     = ght_pkg::gen_nonzero(e_gen);
               rsp.handle_out = {req.new_kind, w_gen,
                                 ght_pkg::SLOT_W'(slot_pos) + ght_pkg::SLOT_W'(1)};
               if (fire) begin
                  wr_en    = 1'b1;
                  head_in  = e_next;
                  count_in = count_ff + PW'(1);
                  if (fresh) begin
                     fill_in = fill_ff + PW'(1);
                  end
               end
            end
         end
         ght_pkg::CMD_RESOLVE: begin
            if (!valid) begin
               rsp.status = ght_pkg::STATUS_INVALID;
            end else begin
               rsp.payload_out = e_payload;
            end
         end
         ght_pkg::CMD_REBIND: begin
            if (!valid) begin
               rsp.status = ght_pkg::STATUS_INVALID;
            end else begin
               w_payload = req.payload;
               wr_en     = fire;
            end
         end
         ght_pkg::CMD_RELEASE: begin
            if (!valid) begin
               rsp.status = ght_pkg::STATUS_INVALID;
            end else begin
               w_occ     = 1'b0;
               w_kind    = '0;
               w_payload = '0;
               w_gen     = ght_pkg::gen_advance(e_gen);
               w_next    = head_ff;
               if (fire) begin
                  wr_en   = 1'b1;
                  head_in = slot_pos;
                  if (count_ff != '0) begin
                     count_in = count_ff - PW'(1);
                  end
               end
            end
         end
         default: begin
            rsp.status = ght_pkg::STATUS_INVALID;
         end
      endcase
      count_wide       = CW'(count_in);
      rsp.live_entries = count_wide[ght_pkg::LIVE_W-1:0];
   end

   assign wr_addr = slot_pos[IW-1:0];
   assign wr_data = {w_payload, w_kind, w_gen, w_next, w_occ};
   assign head    = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         fill_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         fill_ff  <= fill_in;
         count_ff <= count_in;
      end
   end

   `GHT_ASSERT_IMPLIES(a_fill_bound, 1'b1, fill_ff <= SLOT_PTR, "fill count beyond table")
   `GHT_ASSERT_IMPLIES(a_count_in_fill, 1'b1, count_ff <= fill_ff, "live count above fill count")
   `GHT_ASSERT_IMPLIES(a_head_in_fill, 1'b1, head_ff <= fill_ff, "free head past fill count")
   `GHT_ASSERT_NEXT(a_acquire_counts, fire && (req.command == ght_pkg::CMD_ACQUIRE) && (rsp.status == ght_pkg::STATUS_OK), count_ff == $past(count_ff) + PW'(1), "acquire did not count")

endmodule

// ----- rtl/generational_handle_table.sv -----
// ----------------------------------------------------------------------------
// generational_handle_table: slot map handing out 64-bit generational handles
// Flow: slot memory is read on accept of a req item and written back on the execute
//   step, which also loads the result; rsp_tvalid rises once it is loaded, later while a
//   waiting result is held off by rsp_tready. No new item is taken until that step is done.
// Reset: synchronous; no clearing pass, a fill count marks untouched slots.
// ----------------------------------------------------------------------------
`include "generational_handle_table_defines.svh"

module generational_handle_table #(
   parameter int SLOT_COUNT = 1024
) (
   input  logic         clock,
   input  logic         reset,
   // req_tuser: command[1:0]
   // req_tdata: handle[63:0], match_kind[71:64], new_kind[79:72], payload[143:80]
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,
   input  logic [143:0] req_tdata,
   // rsp_tuser: status[1:0]
   // rsp_tdata: handle_out[63:0], payload_out[127:64], live_entries[138:128], zero pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,
   output logic [143:0] rsp_tdata
);

   // Slot index width, and pointer width that also holds the "none" value.
   localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
   localparam int PW = $clog2(SLOT_COUNT + 1);
   // Memory entry: payload, kind, generation, next-free pointer, occupied bit.
   localparam int EW = ght_pkg::PAYLOAD_W + ght_pkg::KIND_W + ght_pkg::GEN_W + PW + 1;

   ght_pkg::state_type state_ff, state_in;
   ght_pkg::req_type   req_ff, req_in;
   ght_pkg::rsp_type   rsp_ff, exec_rsp;
   logic               rsp_valid_ff, rsp_valid_in;

   logic               accept;
   logic               exec_fire;
   logic [PW-1:0]      head;
   logic [ght_pkg::SLOT_W-1:0] enc_m1;
   logic [IW-1:0]      rd_addr;
   logic [EW-1:0]      rd_data;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [EW-1:0]      wr_data;

   // Unpack the incoming item.
   assign req_in.command    = ght_pkg::cmd_type'(req_tuser);
   assign req_in.handle     = req_tdata[63:0];
   assign req_in.match_kind = req_tdata[71:64];
   assign req_in.new_kind   = req_tdata[79:72];
   assign req_in.payload    = req_tdata[143:80];

   assign accept = req_tvalid && req_tready;

   // Read address: the free-list head for acquire, the handle's slot otherwise.
   assign enc_m1  = req_in.handle[ght_pkg::SLOT_W-1:0] - ght_pkg::SLOT_W'(1);
   assign rd_addr = (req_in.command == ght_pkg::CMD_ACQUIRE) ? head[IW-1:0] : enc_m1[IW-1:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ght_pkg::STATE_IDLE: begin
            if (accept) begin
               state_in = ght_pkg::STATE_EXEC;
            end
         end
         ght_pkg::STATE_EXEC: begin
            if (exec_fire) begin
               state_in = ght_pkg::STATE_IDLE;
            end
         end
         default: begin
            state_in = ght_pkg::STATE_IDLE;
         end
      endcase
   end

   // Outputs of the sequencer. Accept in idle even while a result waits;
   // hold the execute step until the output register is free.
   always_comb begin
      req_tready = 1'b0;
      exec_fire  = 1'b0;
      unique case (state_ff)
         ght_pkg::STATE_IDLE: begin
            req_tready = 1'b1;
         end
         ght_pkg::STATE_EXEC: begin
            exec_fire = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (exec_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ght_pkg::STATE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the item on accept; load the result on the execute step.
   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req_in;
      end
      if (exec_fire) begin
         rsp_ff <= exec_rsp;
      end
   end

   ght_slot_ram #(
      .WIDTH (EW),
      .DEPTH (SLOT_COUNT),
      .AW    (IW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (accept),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ght_exec #(
      .SLOT_COUNT (SLOT_COUNT),
      .IW         (IW),
      .PW         (PW),
      .EW         (EW)
   ) u_exec (
      .clock   (clock),
      .reset   (reset),
      .fire    (exec_fire),
      .req     (req_ff),
      .rd_data (rd_data),
      .head    (head),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rsp     (exec_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tdata  = {5'b0, rsp_ff.live_entries, rsp_ff.payload_out, rsp_ff.handle_out};

   `GHT_ASSERT_NEXT(a_accept_execs, accept, state_ff == ght_pkg::STATE_EXEC, "accepted item not executed")
   `GHT_ASSERT_NEXT(a_fire_loads, exec_fire, rsp_valid_ff && (state_ff == ght_pkg::STATE_IDLE), "result not loaded")
   `GHT_ASSERT_NEXT(a_no_phantom, (state_ff == ght_pkg::STATE_IDLE) && rsp_tready, !rsp_valid_ff, "result without execute")

endmodule
